// ===== rtl/dcda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcda_pkg: shared types, constants and helpers
// Widths of the element, rho and accumulator formats, register indexes,
// and the saturation functions for the dual complex dot accumulator.
// ----------------------------------------------------------------------------
package dcda_pkg;

   // Field widths
   localparam int ELEM_W  = 16;   // Q1.15 element and beta
   localparam int RHO_W   = 32;   // Q17.15 rho
   localparam int PROD_W  = 2 * ELEM_W;        // exact Q2.30 element product
   localparam int PSUM_W  = PROD_W + 1;        // sum of two element products
   localparam int ACC_W   = 48;                // Q18.30 accumulator
   localparam int SCL_W   = ELEM_W + RHO_W;    // exact beta*rho product
   localparam int SSUM_W  = SCL_W + 1;         // sum of two beta*rho products
   localparam int FIN_W   = SSUM_W + 1;        // scaled + accumulator
   localparam int FRAC_DROP = 15;              // Q.30 -> Q.15

   // Channels: xz_re, xz_im, yz_re, yz_im (even = real part)
   localparam int CH_N    = 4;

   // Stream widths
   localparam int REQ_DATA_W = 6 * ELEM_W + 4 * RHO_W;
   localparam int RSP_DATA_W = CH_N * RHO_W;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CONJ_MODE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BETA_RE   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BETA_IM   = 2'd2;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [RHO_W-1:0]  rho_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // One captured request
   typedef struct packed {
      elem_type x_re;
      elem_type x_im;
      elem_type y_re;
      elem_type y_im;
      elem_type z_re;
      elem_type z_im;
      rho_type  old_xz_re;
      rho_type  old_xz_im;
      rho_type  old_yz_re;
      rho_type  old_yz_im;
      logic     is_last;
      logic     is_empty;
   } req_type;

   // Saturate a one-bit-grown accumulator sum back to ACC_W
   function automatic acc_type sat_acc(input logic signed [ACC_W:0] v);
      acc_type r;
      if (v[ACC_W] != v[ACC_W-1]) begin
         r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

   // Floor from Q.30 to Q.15, then saturate to rho width
   function automatic rho_type finish_rho(input logic signed [FIN_W-1:0] v);
      logic signed [FIN_W-FRAC_DROP-1:0] q;
      rho_type r;
      q = v[FIN_W-1:FRAC_DROP];   // arithmetic drop of fraction bits = floor
      if (q[FIN_W-FRAC_DROP-1:RHO_W-1] != {(FIN_W-FRAC_DROP-RHO_W+1){1'b0}} &&
          q[FIN_W-FRAC_DROP-1:RHO_W-1] != {(FIN_W-FRAC_DROP-RHO_W+1){1'b1}}) begin
         r = q[FIN_W-FRAC_DROP-1] ? {1'b1, {(RHO_W-1){1'b0}}}
                                  : {1'b0, {(RHO_W-1){1'b1}}};
      end else begin
         r = q[RHO_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/dual_complex_dot_accumulate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_complex_dot_accumulate: fused dual complex dot product
// Accumulates sum(x*z) and sum(y*z) over a stream of element triples and,
// on the last element, returns beta*rho + sum for both dot products.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one element triple (x, y, z) per transfer, plus the prior
//   rho values which are only looked at when req_tlast is set. req_tuser
//   marks an empty item: its elements are not accumulated, so a zero-length
//   vector is sent as a single item with tlast and tuser both high.
//   rsp_* carries one result (new rho_xz, new rho_yz) per vector, produced
//   by the item with tlast; other items produce no transfer.
//   csr_* writes conj_mode and beta; write only while the block is idle.
// Timing:
//   One item per cycle sustained while req_tready stays high. A last
//   item's result reaches rsp_* through the input register, then the
//   multiplier, accumulate and result registers, in that order. The
//   accumulators update from their own value on every transfer, which
//   sets the one-item-per-cycle rate.
// Reset and stalls:
//   Reset clears the accumulators, the configuration and all valid flags.
//   While rsp_tready is low a waiting result holds; items keep entering
//   and accumulating until a second result waits behind it and the input
//   and multiplier registers fill, then req_tready drops.
// ----------------------------------------------------------------------------
module dual_complex_dot_accumulate
   import dcda_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   // Request stream
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // tdata, low bit up: x_re, x_im, y_re, y_im, z_re, z_im (16 each),
   //   old_xz_re, old_xz_im, old_yz_re, old_yz_im (32 each)
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   input  logic                    req_tlast,   // is_last
   input  logic                    req_tuser,   // is_empty

   // Result stream
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // tdata, low bit up: new_xz_re, new_xz_im, new_yz_re, new_yz_im (32 each)
   output logic [RSP_DATA_W-1:0]   rsp_tdata,

   // Configuration writes
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ELEM_W-1:0]       csr_wdata
);

   // Configuration registers
   logic     conj_ff;
   elem_type beta_re_ff;
   elem_type beta_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         conj_ff    <= 1'b0;
         beta_re_ff <= '0;
         beta_im_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CONJ_MODE: conj_ff    <= csr_wdata[0];
            CSR_BETA_RE:   beta_re_ff <= csr_wdata;
            CSR_BETA_IM:   beta_im_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline control
   logic a_valid_ff, b_valid_ff, c_valid_ff, rsp_valid_ff;
   logic out_free, c_ready, b_ready, a_ready;
   logic b_move;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign c_ready    = !c_valid_ff || out_free;
   assign b_ready    = c_ready;           // B moves only when C can take, also for non-last items
   assign a_ready    = !a_valid_ff || b_ready;
   assign req_tready = a_ready;
   assign rsp_tvalid = rsp_valid_ff;

   // Stage A: input register
   req_type a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && req_tvalid) begin
         a_ff.x_re      <= req_tdata[0*ELEM_W +: ELEM_W];
         a_ff.x_im      <= req_tdata[1*ELEM_W +: ELEM_W];
         a_ff.y_re      <= req_tdata[2*ELEM_W +: ELEM_W];
         a_ff.y_im      <= req_tdata[3*ELEM_W +: ELEM_W];
         a_ff.z_re      <= req_tdata[4*ELEM_W +: ELEM_W];
         a_ff.z_im      <= req_tdata[5*ELEM_W +: ELEM_W];
         a_ff.old_xz_re <= req_tdata[6*ELEM_W + 0*RHO_W +: RHO_W];
         a_ff.old_xz_im <= req_tdata[6*ELEM_W + 1*RHO_W +: RHO_W];
         a_ff.old_yz_re <= req_tdata[6*ELEM_W + 2*RHO_W +: RHO_W];
         a_ff.old_yz_im <= req_tdata[6*ELEM_W + 3*RHO_W +: RHO_W];
         a_ff.is_last   <= req_tlast;
         a_ff.is_empty  <= req_tuser;
      end
   end

   // Stage B: multipliers. Per channel p0 = ea*eb, p1 = ec*ed,
   // q0 = beta_re*o0, q1 = beta_im*o1.
   elem_type ea [CH_N];
   elem_type eb [CH_N];
   elem_type ec [CH_N];
   elem_type ed [CH_N];
   rho_type  o0 [CH_N];
   rho_type  o1 [CH_N];

   always_comb begin
      ea[0] = a_ff.x_re; eb[0] = a_ff.z_re; ec[0] = a_ff.x_im; ed[0] = a_ff.z_im;
      ea[1] = a_ff.x_re; eb[1] = a_ff.z_im; ec[1] = a_ff.x_im; ed[1] = a_ff.z_re;
      ea[2] = a_ff.y_re; eb[2] = a_ff.z_re; ec[2] = a_ff.y_im; ed[2] = a_ff.z_im;
      ea[3] = a_ff.y_re; eb[3] = a_ff.z_im; ec[3] = a_ff.y_im; ed[3] = a_ff.z_re;
      o0[0] = a_ff.old_xz_re; o1[0] = a_ff.old_xz_im;
      o0[1] = a_ff.old_xz_im; o1[1] = a_ff.old_xz_re;
      o0[2] = a_ff.old_yz_re; o1[2] = a_ff.old_yz_im;
      o0[3] = a_ff.old_yz_im; o1[3] = a_ff.old_yz_re;
   end

   logic signed [PROD_W-1:0] b_p0_ff [CH_N];
   logic signed [PROD_W-1:0] b_p1_ff [CH_N];
   logic signed [SCL_W-1:0]  b_q0_ff [CH_N];
   logic signed [SCL_W-1:0]  b_q1_ff [CH_N];
   logic                     b_last_ff;
   logic                     b_empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         for (int k = 0; k < CH_N; k++) begin
            b_p0_ff[k] <= ea[k] * eb[k];
            b_p1_ff[k] <= ec[k] * ed[k];
            b_q0_ff[k] <= beta_re_ff * o0[k];
            b_q1_ff[k] <= beta_im_ff * o1[k];
         end
         b_last_ff  <= a_ff.is_last;
         b_empty_ff <= a_ff.is_empty;
      end
   end

   // Stage C: accumulate and form beta*rho.
   // Real channels subtract the cross product, imaginary ones add;
   // conjugation flips that for the element sum only.
   logic signed [PSUM_W-1:0] psum_in    [CH_N];
   logic signed [ACC_W:0]    acc_sum_in [CH_N];
   acc_type                  acc_new_in [CH_N];
   logic signed [SSUM_W-1:0] scaled_in  [CH_N];
   acc_type                  acc_ff     [CH_N];

   always_comb begin
      for (int k = 0; k < CH_N; k++) begin
         if ((k % 2 == 0) ^ conj_ff) begin
            psum_in[k] = PSUM_W'(b_p0_ff[k]) - PSUM_W'(b_p1_ff[k]);
         end else begin
            psum_in[k] = PSUM_W'(b_p0_ff[k]) + PSUM_W'(b_p1_ff[k]);
         end
         acc_sum_in[k] = (ACC_W + 1)'(acc_ff[k]) + (ACC_W + 1)'(psum_in[k]);
         acc_new_in[k] = b_empty_ff ? acc_ff[k] : sat_acc(acc_sum_in[k]);
         if (k % 2 == 0) begin
            scaled_in[k] = SSUM_W'(b_q0_ff[k]) - SSUM_W'(b_q1_ff[k]);
         end else begin
            scaled_in[k] = SSUM_W'(b_q0_ff[k]) + SSUM_W'(b_q1_ff[k]);
         end
      end
   end

   assign b_move = b_valid_ff && b_ready;

   // Accumulator loop: cleared after the last element of a vector
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CH_N; k++) begin
            acc_ff[k] <= '0;
         end
      end else if (b_move) begin
         for (int k = 0; k < CH_N; k++) begin
            acc_ff[k] <= b_last_ff ? '0 : acc_new_in[k];
         end
      end
   end

   // Only last items go on to the result path
   acc_type                  c_acc_ff    [CH_N];
   logic signed [SSUM_W-1:0] c_scaled_ff [CH_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_move && b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && b_move && b_last_ff) begin
         for (int k = 0; k < CH_N; k++) begin
            c_acc_ff[k]    <= acc_new_in[k];
            c_scaled_ff[k] <= scaled_in[k];
         end
      end
   end

   // Stage D: final add, floor to Q.15, saturate into the result register
   logic signed [FIN_W-1:0] fin_in [CH_N];
   rho_type                 rsp_ff [CH_N];

   always_comb begin
      for (int k = 0; k < CH_N; k++) begin
         fin_in[k] = FIN_W'(c_scaled_ff[k]) + FIN_W'(c_acc_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && c_valid_ff) begin
         for (int k = 0; k < CH_N; k++) begin
            rsp_ff[k] <= finish_rho(fin_in[k]);
         end
      end
   end

   assign rsp_tdata = {rsp_ff[3], rsp_ff[2], rsp_ff[1], rsp_ff[0]};

   // Checks
   a_result_held : assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && !out_free) |=> c_valid_ff)
      else $error("pending result dropped while output stalled");

   a_acc_cleared : assert property (@(posedge clock) disable iff (reset)
      (b_move && b_last_ff) |=>
         (acc_ff[0] == '0 && acc_ff[1] == '0 && acc_ff[2] == '0 && acc_ff[3] == '0))
      else $error("accumulators not cleared after last element");

   a_ready_block : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (a_valid_ff && c_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input blocked while the result path can move");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(c_valid_ff))
      else $error("result appeared without a completed vector");

endmodule

// ===== tb/tb_dual_complex_dot_accumulate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_complex_dot_accumulate: self-checking bench for the dual dot product
// Streams element triples into the block and predicts each result with a
// cycle-free software copy of the accumulators and configuration. Results
// are checked field by field in order. Covers directed corner cases,
// randomized vectors under several beta and conjugation settings, random
// stalls on both streams, a long output back-pressure and one long vector
// of full-size terms at full rate.
// ----------------------------------------------------------------------------
module tb_dual_complex_dot_accumulate;
   import dcda_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;   // unmapped index

   localparam elem_type ELEM_MIN = 16'sh8000;
   localparam elem_type ELEM_MAX = 16'sh7fff;
   localparam rho_type  RHO_MIN  = 32'sh8000_0000;
   localparam rho_type  RHO_MAX  = 32'sh7fff_ffff;

   localparam longint ACC_TOP = 64'sh0000_7fff_ffff_ffff;
   localparam longint ACC_BOT = -ACC_TOP - 1;
   localparam longint RHO_TOP = 64'sd2147483647;
   localparam longint RHO_BOT = -RHO_TOP - 1;

   localparam int DRAIN_CYCLES = 8;        // result path is four stages deep
   localparam int IDLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS  = 200;
   localparam int LONG_LEN     = 64;       // full-size terms back to back
   localparam int LONG_HOLD    = 300;

   // One result, laid out as on rsp_tdata (xz_re in the low bits)
   typedef struct packed {
      rho_type yz_im;
      rho_type yz_re;
      rho_type xz_im;
      rho_type xz_re;
   } dot_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [ELEM_W-1:0]     csr_wdata = '0;

   // Stimulus and expectation stores
   req_type        element_q[$];
   dot_result_type pending_rho[$];

   // Software copy of the block
   bit       m_conj = 1'b0;
   elem_type m_beta_re = '0;
   elem_type m_beta_im = '0;
   acc_type  acc_xz_re = '0;
   acc_type  acc_xz_im = '0;
   acc_type  acc_yz_re = '0;
   acc_type  acc_yz_im = '0;

   // Handshake pacing
   logic req_took = 1'b0;
   int   send_gap = 0;
   int   send_idle_pct = 15;
   int   recv_idle_pct = 15;
   int   rsp_hold = 0;
   bit   hold_rsp_request = 1'b0;
   bit   hold_rsp_started = 1'b0;
   int   fails = 0;

   dual_complex_dot_accumulate dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Accumulate with saturation at the 48-bit signed range
   function automatic acc_type acc_sum(acc_type a, longint b);
      longint s;
      s = longint'(a) + b;
      if (s > ACC_TOP) s = ACC_TOP;
      else if (s < ACC_BOT) s = ACC_BOT;
      return acc_type'(s);
   endfunction

   // Q.30 -> Q.15 by floor, then clamp to 32-bit signed
   function automatic rho_type to_rho(longint scaled, acc_type a);
      longint q;
      q = (scaled + longint'(a)) >>> 15;
      if (q > RHO_TOP) q = RHO_TOP;
      else if (q < RHO_BOT) q = RHO_BOT;
      return rho_type'(q);
   endfunction

   // Advance both dot products by one transfer; queue a result on tlast
   function automatic void step_dot_products(req_type it);
      longint xr, xi, yr, yi, zr, zi, br, bi;
      dot_result_type r;
      br = m_beta_re;
      bi = m_beta_im;
      if (!it.is_empty) begin
         xr = it.x_re;
         xi = it.x_im;
         yr = it.y_re;
         yi = it.y_im;
         zr = it.z_re;
         zi = it.z_im;
         if (m_conj) begin
            xi = -xi;
            yi = -yi;
         end
         acc_xz_re = acc_sum(acc_xz_re, xr * zr - xi * zi);
         acc_xz_im = acc_sum(acc_xz_im, xr * zi + xi * zr);
         acc_yz_re = acc_sum(acc_yz_re, yr * zr - yi * zi);
         acc_yz_im = acc_sum(acc_yz_im, yr * zi + yi * zr);
      end
      if (it.is_last) begin
         r.xz_re = to_rho(br * it.old_xz_re - bi * it.old_xz_im, acc_xz_re);
         r.xz_im = to_rho(br * it.old_xz_im + bi * it.old_xz_re, acc_xz_im);
         r.yz_re = to_rho(br * it.old_yz_re - bi * it.old_yz_im, acc_yz_re);
         r.yz_im = to_rho(br * it.old_yz_im + bi * it.old_yz_re, acc_yz_im);
         pending_rho.push_back(r);
         acc_xz_re = '0;
         acc_xz_im = '0;
         acc_yz_re = '0;
         acc_yz_im = '0;
      end
   endfunction

   function automatic void compare_rho(string name, rho_type want, rho_type got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fails++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: config writes, request transfers, result transfers
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      req_type        seen;
      dot_result_type got, want;
      req_took <= req_tvalid && req_tready;
      if (!reset) begin
         if (csr_we) begin
            case (csr_addr)
               CSR_CONJ_MODE: m_conj = csr_wdata[0];
               CSR_BETA_RE:   m_beta_re = csr_wdata;
               CSR_BETA_IM:   m_beta_im = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_rho.size() == 0) begin
               $error("result transfer with no result expected: %h", rsp_tdata);
               fails++;
            end else begin
               want = pending_rho.pop_front();
               compare_rho("new_xz_re", want.xz_re, got.xz_re);
               compare_rho("new_xz_im", want.xz_im, got.xz_im);
               compare_rho("new_yz_re", want.yz_re, got.yz_re);
               compare_rho("new_yz_im", want.yz_im, got.yz_im);
            end
         end
         if (req_tvalid && req_tready) begin
            seen.x_re      = req_tdata[15:0];
            seen.x_im      = req_tdata[31:16];
            seen.y_re      = req_tdata[47:32];
            seen.y_im      = req_tdata[63:48];
            seen.z_re      = req_tdata[79:64];
            seen.z_im      = req_tdata[95:80];
            seen.old_xz_re = req_tdata[127:96];
            seen.old_xz_im = req_tdata[159:128];
            seen.old_yz_re = req_tdata[191:160];
            seen.old_yz_im = req_tdata[223:192];
            seen.is_last   = req_tlast;
            seen.is_empty  = req_tuser;
            step_dot_products(seen);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request driver: random idle bursts between transfers
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      req_type nxt;
      if (reset || (req_tvalid && !req_took)) begin
         // hold the offered item until it transfers
      end else if (send_gap != 0) begin
         send_gap   <= send_gap - 1;
         req_tvalid <= 1'b0;
      end else if (element_q.size() != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         send_gap   <= $urandom_range(0, 13);
         req_tvalid <= 1'b0;
      end else if (element_q.size() != 0) begin
         nxt = element_q.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= {nxt.old_yz_im, nxt.old_yz_re, nxt.old_xz_im, nxt.old_xz_re,
                        nxt.z_im, nxt.z_re, nxt.y_im, nxt.y_re, nxt.x_im, nxt.x_re};
         req_tlast  <= nxt.is_last;
         req_tuser  <= nxt.is_empty;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver: random stall bursts, plus one long hold on request
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_rsp_request && !hold_rsp_started) begin
         hold_rsp_started <= 1'b1;
         rsp_hold   <= LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
         rsp_hold   <= $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic elem_type rand_elem();
      elem_type v;
      case ($urandom_range(0, 7))
         0: v = ELEM_MIN;
         1: v = ELEM_MAX;
         2: v = '0;
         3: begin
            v = elem_type'($urandom_range(0, 255));
            v = v - 16'sd128;
         end
         default: v = elem_type'($urandom);
      endcase
      return v;
   endfunction

   function automatic rho_type rand_rho();
      rho_type v;
      case ($urandom_range(0, 7))
         0: v = RHO_MIN;
         1: v = RHO_MAX;
         2: v = '0;
         3: v = -32'sd1;
         default: v = rho_type'($urandom);
      endcase
      return v;
   endfunction

   function automatic req_type make_item(elem_type xr, elem_type xi, elem_type yr,
                                         elem_type yi, elem_type zr, elem_type zi,
                                         rho_type oxr, rho_type oxi, rho_type oyr,
                                         rho_type oyi, bit last, bit empty);
      req_type it;
      it.x_re = xr;
      it.x_im = xi;
      it.y_re = yr;
      it.y_im = yi;
      it.z_re = zr;
      it.z_im = zi;
      it.old_xz_re = oxr;
      it.old_xz_im = oxi;
      it.old_yz_re = oyr;
      it.old_yz_im = oyi;
      it.is_last  = last;
      it.is_empty = empty;
      return it;
   endfunction

   function automatic req_type rand_item(bit last, bit empty);
      return make_item(rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                       rand_elem(), rand_rho(), rand_rho(), rand_rho(), rand_rho(),
                       last, empty);
   endfunction

   // Mostly well-formed vectors, some zero-length ones and some loose items
   task automatic push_random_vectors(int target);
      int pushed, len, kind;
      pushed = 0;
      while (pushed < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 15) == 0) element_q.push_back(rand_item(1'b0, 1'b1));
               element_q.push_back(rand_item(i == len - 1, 1'b0));
               pushed++;
            end
         end else if (kind < 90) begin
            element_q.push_back(rand_item(1'b1, 1'b1));
            pushed++;
         end else begin
            element_q.push_back(rand_item(1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1))));
            pushed++;
         end
      end
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] a, logic [ELEM_W-1:0] d);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= d;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Upper bits of the conj_mode write are don't-care; keep them random
   task automatic load_config(bit conj, elem_type bre, elem_type bim);
      logic [ELEM_W-1:0] w;
      w = ELEM_W'($urandom);
      w[0] = conj;
      csr_write(CSR_CONJ_MODE, w);
      csr_write(CSR_BETA_RE, bre);
      csr_write(CSR_BETA_IM, bim);
   endtask

   // Wait until every item has transferred and every result has arrived
   task automatic wait_quiet();
      int n;
      n = 0;
      while ((element_q.size() != 0 || req_tvalid || pending_rho.size() != 0) &&
             n < IDLE_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (n >= IDLE_LIMIT) begin
         $error("%0d results never arrived", pending_rho.size());
         fails++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(bit conj, elem_type bre, elem_type bim, int sidle, int ridle);
      load_config(conj, bre, bim);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      push_random_vectors(PHASE_ITEMS);
      wait_quiet();
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset config (beta zero): empty vector, extreme elements, ignored item
      element_q.push_back(make_item('0, '0, '0, '0, '0, '0,
                                    RHO_MAX, RHO_MAX, RHO_MAX, RHO_MAX, 1'b1, 1'b1));
      element_q.push_back(make_item(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN,
                                    ELEM_MIN, RHO_MIN, RHO_MIN, RHO_MIN, RHO_MIN,
                                    1'b1, 1'b0));
      element_q.push_back(rand_item(1'b0, 1'b1));
      element_q.push_back(make_item(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX,
                                    ELEM_MAX, RHO_MAX, RHO_MIN, RHO_MAX, RHO_MIN,
                                    1'b1, 1'b0));
      wait_quiet();

      // Conjugated, beta = -1 - 1j: result saturation and beta*old after a result
      load_config(1'b1, ELEM_MIN, ELEM_MIN);
      element_q.push_back(make_item(ELEM_MIN, ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MIN,
                                    ELEM_MAX, '0, '0, '0, '0, 1'b0, 1'b0));
      element_q.push_back(rand_item(1'b0, 1'b1));
      element_q.push_back(make_item(ELEM_MAX, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN,
                                    ELEM_MIN, RHO_MIN, RHO_MAX, RHO_MAX, RHO_MIN,
                                    1'b1, 1'b0));
      element_q.push_back(make_item('0, '0, '0, '0, '0, '0,
                                    RHO_MAX, RHO_MAX, RHO_MIN, RHO_MAX, 1'b1, 1'b1));
      element_q.push_back(make_item(ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX,
                                    ELEM_MIN, RHO_MIN, RHO_MIN, RHO_MIN, RHO_MIN,
                                    1'b1, 1'b1));
      wait_quiet();

      // Plain, beta near 1 + 1j: short vector, zero olds, floor of small negatives
      load_config(1'b0, ELEM_MAX, ELEM_MAX);
      element_q.push_back(make_item(ELEM_MIN, ELEM_MAX, ELEM_MAX, ELEM_MIN, ELEM_MIN,
                                    ELEM_MIN, '0, '0, '0, '0, 1'b0, 1'b0));
      element_q.push_back(rand_item(1'b0, 1'b0));
      element_q.push_back(rand_item(1'b1, 1'b0));
      element_q.push_back(make_item('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1, 1'b1));
      element_q.push_back(make_item(16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1,
                                    -32'sd1, -32'sd1, -32'sd1, 32'sd1, 1'b1, 1'b0));
      wait_quiet();

      // Randomized vectors under several settings
      run_phase(1'b0, ELEM_MAX, '0, 10, 10);
      hold_rsp_request = 1'b1;   // output held off long enough to back up the input
      run_phase(1'b1, ELEM_MIN, ELEM_MIN, 20, 5);
      run_phase(1'b0, ELEM_MIN, ELEM_MAX, 0, 30);
      run_phase(1'b1, elem_type'($urandom), elem_type'($urandom), 30, 30);
      csr_write(CSR_SPARE, ELEM_W'($urandom));
      run_phase(1'b0, '0, '0, 5, 0);

      // One long vector of full-size terms: xz_re grows positive and
      // yz_re negative at the largest step per item
      load_config(1'b0, elem_type'($urandom), elem_type'($urandom));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < LONG_LEN; i++) begin
         element_q.push_back(make_item(ELEM_MIN, ELEM_MIN, ELEM_MAX, ELEM_MAX, ELEM_MIN,
                                       ELEM_MAX, rand_rho(), rand_rho(), rand_rho(),
                                       rand_rho(), i == LONG_LEN - 1, 1'b0));
      end
      wait_quiet();

      // Closing stretch at full rate
      run_phase(1'b1, elem_type'($urandom), elem_type'($urandom), 0, 0);

      if (fails == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== dual_complex_dot_accumulate.f =====
rtl/dcda_pkg.sv
rtl/dual_complex_dot_accumulate.sv
tb/tb_dual_complex_dot_accumulate.sv
